// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is applied.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_RAW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lpr_pkg.sv =====
// Package for the line pixel rasterizer: widths, defaults and the command type.
package lpr_pkg;

  localparam int LPR_COORD_W     = 6;
  localparam int LPR_COLOUR_W    = 16;
  localparam int LPR_ERR_W       = 9;
  localparam int LPR_TILE_SIZE   = 64;
  localparam int LPR_QUEUE_DEPTH = 2;

  typedef logic [LPR_COORD_W-1:0]         coord_t;
  typedef logic [LPR_COLOUR_W-1:0]        colour_t;
  typedef logic signed [LPR_ERR_W-1:0]    err_t;

  // Classified line command handed from the front end to the walker
  typedef struct packed {
    coord_t  cur_x;
    coord_t  cur_y;
    coord_t  end_x;
    coord_t  end_y;
    coord_t  dx;
    coord_t  dy;
    logic    x_dec;   // x walks downwards
    logic    y_dec;   // y walks downwards
    err_t    err;
    colour_t colour;
  } lpr_cmd_t;

endpackage

// ===== sv/line_pixel_rasterizer.sv =====
// Top level of the line pixel rasterizer: front end, command queue, walker.
//
// Input channel (in_valid/in_ready): one line command per transfer, start
// and end points plus a 16-bit colour. Coordinates at or above TILE_SIZE
// are saturated to TILE_SIZE - 1. Commands go into a QUEUE_DEPTH-entry
// queue, so in_ready stays high while the queue has room.
// Output channel (out_valid/out_ready): one pixel per transfer, in walking
// order from start to end inclusive; out_last_pixel marks the end point.
// A command passes through a queue slot and, once the walker is free, the
// walker's command register before its first pixel shows on out_valid.
// Throughput: the walker gives one pixel per cycle while the receiver does not
// stall, so a line yields max(|dx|, |dy|) + 1 pixels, at most TILE_SIZE, and
// the walker loads the next command from the queue only after its last pixel.
// When the receiver stalls, the pixel in the output register holds and the
// walker waits; the front end keeps taking commands until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, idles the walker and
// drops out_valid; no state is kept between commands.
module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int TILE_SIZE   = LPR_TILE_SIZE,
  parameter int QUEUE_DEPTH = LPR_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  coord_t  in_start_x,
  input  coord_t  in_start_y,
  input  coord_t  in_end_x,
  input  coord_t  in_end_y,
  input  colour_t in_line_colour,
  output logic    out_valid,
  input  logic    out_ready,
  output coord_t  out_pixel_x,
  output coord_t  out_pixel_y,
  output colour_t out_pixel_colour,
  output logic    out_last_pixel
);

  logic     q_push, q_full, q_pop, q_valid;
  lpr_cmd_t push_cmd, pop_cmd;

  // Command intake and setup
  lpr_front #(
    .TILE_SIZE (TILE_SIZE)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_line_colour (in_line_colour),
    .q_push         (q_push),
    .q_cmd          (push_cmd),
    .q_full         (q_full)
  );

  // Decoupling queue
  lpr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  // Pixel walker
  lpr_walk u_walk (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

// ===== sv/lpr_front.sv =====
// Front end: takes line commands, clamps endpoints and sets up the walk.
module lpr_front
  import lpr_pkg::*;
#(
  parameter int TILE_SIZE = LPR_TILE_SIZE
) (
  input  logic     in_valid,
  output logic     in_ready,
  input  coord_t   in_start_x,
  input  coord_t   in_start_y,
  input  coord_t   in_end_x,
  input  coord_t   in_end_y,
  input  colour_t  in_line_colour,
  output logic     q_push,
  output lpr_cmd_t q_cmd,
  input  logic     q_full
);

  localparam coord_t MaxCoord = LPR_COORD_W'(TILE_SIZE - 1);

  coord_t cx, cy, tx, ty;
  coord_t dx, dy;

  // Saturate endpoints to the tile
  assign cx = (in_start_x > MaxCoord) ? MaxCoord : in_start_x;
  assign cy = (in_start_y > MaxCoord) ? MaxCoord : in_start_y;
  assign tx = (in_end_x   > MaxCoord) ? MaxCoord : in_end_x;
  assign ty = (in_end_y   > MaxCoord) ? MaxCoord : in_end_y;

  // Spans and walking directions
  assign dx = (tx > cx) ? (tx - cx) : (cx - tx);
  assign dy = (ty > cy) ? (ty - cy) : (cy - ty);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.cur_x  = cx;
    q_cmd.cur_y  = cy;
    q_cmd.end_x  = tx;
    q_cmd.end_y  = ty;
    q_cmd.dx     = dx;
    q_cmd.dy     = dy;
    q_cmd.x_dec  = !(cx < tx);
    q_cmd.y_dec  = !(cy < ty);
    q_cmd.err    = $signed({{(LPR_ERR_W-LPR_COORD_W){1'b0}}, dx})
                 - $signed({{(LPR_ERR_W-LPR_COORD_W){1'b0}}, dy});
    q_cmd.colour = in_line_colour;
  end

endmodule

// ===== sv/lpr_fifo.sv =====
// Short command queue between the front end and the walker.
module lpr_fifo
  import lpr_pkg::*;
#(
  parameter int DEPTH = LPR_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lpr_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output lpr_cmd_t pop_cmd,
  output logic     not_empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  lpr_cmd_t          slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == FullCnt);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = slot_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/lpr_walk.sv =====
// Back end: Bresenham walk, one pixel per cycle into an output register unless the receiver stalls.
module lpr_walk
  import lpr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  lpr_cmd_t q_cmd,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output coord_t   out_pixel_x,
  output coord_t   out_pixel_y,
  output colour_t  out_pixel_colour,
  output logic     out_last_pixel
);

  localparam int E2W = LPR_ERR_W + 1;
  localparam int PadW = E2W - LPR_COORD_W;

  logic     busy_r, busy_nxt;
  lpr_cmd_t walk_r, walk_nxt;
  logic     out_valid_r, out_valid_nxt;
  coord_t   pix_x_r, pix_y_r;
  colour_t  pix_colour_r;
  logic     pix_last_r;

  logic                  at_end, advance;
  logic                  step_x, step_y;
  logic signed [E2W-1:0] e2, neg_dy, dx_ext;

  assign at_end  = (walk_r.cur_x == walk_r.end_x) && (walk_r.cur_y == walk_r.end_y);
  assign advance = busy_r && (!out_valid_r || out_ready);
  assign q_pop   = !busy_r && q_valid;

  // Error term decisions
  assign e2     = {walk_r.err, 1'b0};
  assign dx_ext = $signed({{PadW{1'b0}}, walk_r.dx});
  assign neg_dy = -$signed({{PadW{1'b0}}, walk_r.dy});
  assign step_x = (e2 > neg_dy);
  assign step_y = (e2 < dx_ext);

  // Walker state update
  always_comb begin
    busy_nxt = busy_r;
    walk_nxt = walk_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      walk_nxt = q_cmd;
    end else if (advance) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        if (step_x) begin
          walk_nxt.cur_x = walk_r.x_dec ? walk_r.cur_x - 1'b1 : walk_r.cur_x + 1'b1;
        end
        if (step_y) begin
          walk_nxt.cur_y = walk_r.y_dec ? walk_r.cur_y - 1'b1 : walk_r.cur_y + 1'b1;
        end
        walk_nxt.err = walk_r.err
                     - (step_x ? $signed({{(LPR_ERR_W-LPR_COORD_W){1'b0}}, walk_r.dy})
                               : err_t'(0))
                     + (step_y ? $signed({{(LPR_ERR_W-LPR_COORD_W){1'b0}}, walk_r.dx})
                               : err_t'(0));
      end
    end
  end

  // Output register valid
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r <= walk_nxt;
    if (advance) begin
      pix_x_r      <= walk_r.cur_x;
      pix_y_r      <= walk_r.cur_y;
      pix_colour_r <= walk_r.colour;
      pix_last_r   <= at_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = pix_x_r;
  assign out_pixel_y      = pix_y_r;
  assign out_pixel_colour = pix_colour_r;
  assign out_last_pixel   = pix_last_r;

endmodule

// ===== sv/lpr_checker.sv =====
// Port-level checker for the line pixel rasterizer, bound to the top level.
`include "assert_macros.svh"

module lpr_checker
  import lpr_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input coord_t  out_pixel_x,
  input coord_t  out_pixel_y,
  input colour_t out_pixel_colour,
  input logic    out_last_pixel
);

  coord_t  prev_x_r, prev_y_r;
  colour_t prev_colour_r;
  logic    prev_last_r;
  coord_t  dx_step, dy_step;
  logic    px_moved, px_adjacent, px_held, colour_same, line_go;

  // Pixel shown on the previous cycle
  always_ff @(posedge clk) begin
    prev_x_r      <= out_pixel_x;
    prev_y_r      <= out_pixel_y;
    prev_colour_r <= out_pixel_colour;
    prev_last_r   <= out_last_pixel;
  end

  // Step from the previous pixel, modulo the coordinate width
  assign dx_step     = out_pixel_x - prev_x_r;
  assign dy_step     = out_pixel_y - prev_y_r;
  assign px_moved    = (dx_step != '0) || (dy_step != '0);
  assign px_adjacent = (dx_step inside {6'd0, 6'd1, 6'd63})
                    && (dy_step inside {6'd0, 6'd1, 6'd63}) && px_moved;
  assign colour_same = (out_pixel_colour == prev_colour_r);
  assign px_held     = !px_moved && colour_same && (out_last_pixel == prev_last_r);
  assign line_go     = out_valid && out_ready && !out_last_pixel;

  // Reset leaves no pixel pending and the queue open
  `ASSERT_RAW(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready, "not idle after reset")

  // A stalled pixel holds its payload
  `ASSERT_CLKD(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && px_held, "stalled pixel changed")

  // Consecutive pixels of one line are 8-connected neighbors
  `ASSERT_CLKD(a_step_adjacent, clk, rst_n, line_go ##1 out_valid |-> px_adjacent, "pixel step not adjacent")

  // Colour stays fixed along a line
  `ASSERT_CLKD(a_colour_kept, clk, rst_n, line_go ##1 out_valid |-> colour_same, "colour changed in a line")

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);

// ===== tb/sv/line_pixel_rasterizer_test.sv =====
// Self-checking testbench for line_pixel_rasterizer: directed and random line commands.
`timescale 1ns / 1ps

module line_pixel_rasterizer_test;
  import lpr_pkg::*;

  localparam int TILE           = LPR_TILE_SIZE;
  localparam int N_DIRECTED     = 24;
  localparam int RANDOM_LINES   = 340;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 80;

  // One pixel as it leaves the block
  typedef struct packed {
    coord_t  x;
    coord_t  y;
    colour_t colour;
    logic    last;
  } pixel_t;

  // One line command; typed rows carry their single expected pixel
  typedef struct packed {
    coord_t  sx;
    coord_t  sy;
    coord_t  ex;
    coord_t  ey;
    colour_t colour;
    logic    has_typed;
    pixel_t  typed_px;
  } line_cmd_t;

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  coord_t  in_start_x;
  coord_t  in_start_y;
  coord_t  in_end_x;
  coord_t  in_end_y;
  colour_t in_line_colour;
  logic    out_valid;
  logic    out_ready;
  coord_t  out_pixel_x;
  coord_t  out_pixel_y;
  colour_t out_pixel_colour;
  logic    out_last_pixel;

  pixel_t pending_pixels[$];
  int     fail_count  = 0;
  int     idle_cycles = 0;
  logic   calm        = 1'b0;   // no new gaps on either side while set

  // Directed lines: extremes, all octants, axis-aligned, single points
  line_cmd_t directed_lines [N_DIRECTED] = '{
    '{6'd0,  6'd0,  6'd0,  6'd0,  16'h0000, 1'b1, '{6'd0,  6'd0,  16'h0000, 1'b1}},
    '{6'd63, 6'd63, 6'd63, 6'd63, 16'hFFFF, 1'b1, '{6'd63, 6'd63, 16'hFFFF, 1'b1}},
    '{6'd0,  6'd63, 6'd0,  6'd63, 16'h8000, 1'b1, '{6'd0,  6'd63, 16'h8000, 1'b1}},
    '{6'd63, 6'd0,  6'd63, 6'd0,  16'h0001, 1'b1, '{6'd63, 6'd0,  16'h0001, 1'b1}},
    '{6'd0,  6'd0,  6'd63, 6'd63, 16'hAAAA, 1'b0, '0},
    '{6'd63, 6'd63, 6'd0,  6'd0,  16'h5555, 1'b0, '0},
    '{6'd0,  6'd63, 6'd63, 6'd0,  16'hF800, 1'b0, '0},
    '{6'd63, 6'd0,  6'd0,  6'd63, 16'h07E0, 1'b0, '0},
    '{6'd0,  6'd10, 6'd63, 6'd10, 16'h001F, 1'b0, '0},
    '{6'd63, 6'd10, 6'd0,  6'd10, 16'hFFE0, 1'b0, '0},
    '{6'd10, 6'd0,  6'd10, 6'd63, 16'h1234, 1'b0, '0},
    '{6'd10, 6'd63, 6'd10, 6'd0,  16'hEDCB, 1'b0, '0},
    '{6'd20, 6'd20, 6'd50, 6'd30, 16'h0F0F, 1'b0, '0},
    '{6'd20, 6'd20, 6'd30, 6'd50, 16'hF0F0, 1'b0, '0},
    '{6'd40, 6'd40, 6'd10, 6'd30, 16'h3C3C, 1'b0, '0},
    '{6'd40, 6'd40, 6'd30, 6'd10, 16'hC3C3, 1'b0, '0},
    '{6'd20, 6'd40, 6'd50, 6'd30, 16'h6666, 1'b0, '0},
    '{6'd20, 6'd40, 6'd30, 6'd10, 16'h9999, 1'b0, '0},
    '{6'd40, 6'd20, 6'd10, 6'd30, 16'h7777, 1'b0, '0},
    '{6'd40, 6'd20, 6'd30, 6'd50, 16'h8888, 1'b0, '0},
    '{6'd5,  6'd5,  6'd6,  6'd6,  16'h0101, 1'b0, '0},
    '{6'd0,  6'd0,  6'd1,  6'd0,  16'h1010, 1'b0, '0},
    '{6'd33, 6'd33, 6'd33, 6'd32, 16'hBEEF, 1'b0, '0},
    '{6'd0,  6'd1,  6'd63, 6'd0,  16'h4321, 1'b0, '0}
  };

  line_pixel_rasterizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_colour  (in_line_colour),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_colour(out_pixel_colour),
    .out_last_pixel  (out_last_pixel)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a coordinate to the tile
  function automatic int clamp_to_tile(coord_t v);
    return (int'(v) > TILE - 1) ? TILE - 1 : int'(v);
  endfunction

  // Keep a computed coordinate inside 0..63
  function automatic coord_t fit_coord(int v);
    if (v < 0) return coord_t'(0);
    if (v > 63) return coord_t'(63);
    return coord_t'(v);
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                       : int'($urandom_range(1, 3));
  endfunction

  // Bresenham walk from start to end; queues every pixel of the line
  function automatic void trace_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
                                     colour_t c);
    int     cx, cy, tx, ty, dx, dy, sgx, sgy, err, e2, n;
    pixel_t px;
    cx  = clamp_to_tile(sx);
    cy  = clamp_to_tile(sy);
    tx  = clamp_to_tile(ex);
    ty  = clamp_to_tile(ey);
    dx  = (tx > cx) ? tx - cx : cx - tx;
    dy  = (ty > cy) ? ty - cy : cy - ty;
    sgx = (cx < tx) ? 1 : -1;
    sgy = (cy < ty) ? 1 : -1;
    err = dx - dy;
    n   = 0;
    while (n < TILE) begin
      px.x      = coord_t'(cx);
      px.y      = coord_t'(cy);
      px.colour = c;
      px.last   = (cx == tx) && (cy == ty);
      pending_pixels.push_back(px);
      n++;
      if (px.last) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        cx  += sgx;
      end
      if (e2 < dx) begin
        err += dx;
        cy  += sgy;
      end
    end
  endfunction

  function automatic void report_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  // Present one command, hold it until the transfer, then queue its pixels
  task automatic send_line(line_cmd_t cmd);
    int gap;
    gap = (!calm && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_start_x     <= cmd.sx;
    in_start_y     <= cmd.sy;
    in_end_x       <= cmd.ex;
    in_end_y       <= cmd.ey;
    in_line_colour <= cmd.colour;
    do @(posedge clk); while (!in_ready);
    if (cmd.has_typed)
      pending_pixels.push_back(cmd.typed_px);
    else
      trace_line(cmd.sx, cmd.sy, cmd.ex, cmd.ey, cmd.colour);
  endtask

  // Stop sending until every queued pixel has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, none started while calm
  initial begin : receiver
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Pixel checker and watchdog
  always @(posedge clk) begin : pixel_monitor
    pixel_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_pixels.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pixel, expected none got x=%0d y=%0d", $time,
                   out_pixel_x, out_pixel_y);
        end else begin
          want = pending_pixels.pop_front();
          report_field("pixel_x", 16'(want.x), 16'(out_pixel_x));
          report_field("pixel_y", 16'(want.y), 16'(out_pixel_y));
          report_field("pixel_colour", want.colour, out_pixel_colour);
          report_field("last_pixel", 16'(want.last), 16'(out_last_pixel));
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    line_cmd_t cmd;
    int        kind, span;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_start_x     = '0;
    in_start_y     = '0;
    in_end_x       = '0;
    in_end_y       = '0;
    in_line_colour = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < N_DIRECTED; i++) send_line(directed_lines[i]);
    drain();

    // Random lines
    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i == RANDOM_LINES / 2) drain();
      calm          = (i >= 120 && i < 180);
      cmd           = '0;
      cmd.colour    = colour_t'($urandom);
      cmd.sx        = coord_t'($urandom);
      cmd.sy        = coord_t'($urandom);
      cmd.ex        = coord_t'($urandom);
      cmd.ey        = coord_t'($urandom);
      kind          = $urandom_range(0, 9);
      case (kind)
        4, 5: begin
          // short line near the start point
          cmd.ex = fit_coord(int'(cmd.sx) + int'($urandom_range(0, 12)) - 6);
          cmd.ey = fit_coord(int'(cmd.sy) + int'($urandom_range(0, 12)) - 6);
        end
        6: begin
          // horizontal or vertical
          if ($urandom_range(0, 1)) cmd.ey = cmd.sy;
          else cmd.ex = cmd.sx;
        end
        7: begin
          // diagonal, exact unless the y end wraps at the tile edge
          span   = $urandom_range(0, 63);
          cmd.ex = fit_coord($urandom_range(0, 1) ? int'(cmd.sx) + span : int'(cmd.sx) - span);
          span   = (cmd.ex > cmd.sx) ? int'(cmd.ex - cmd.sx) : int'(cmd.sx - cmd.ex);
          cmd.ey = ($urandom_range(0, 1) && int'(cmd.sy) + span <= 63) ?
                   coord_t'(int'(cmd.sy) + span) :
                   (int'(cmd.sy) - span >= 0) ? coord_t'(int'(cmd.sy) - span) :
                   coord_t'(int'(cmd.sy) + span);
        end
        8: begin
          // single point
          cmd.ex = cmd.sx;
          cmd.ey = cmd.sy;
        end
        9: begin
          // corners of the tile
          cmd.sx = $urandom_range(0, 1) ? 6'd63 : 6'd0;
          cmd.sy = $urandom_range(0, 1) ? 6'd63 : 6'd0;
          cmd.ex = $urandom_range(0, 1) ? 6'd63 : 6'd0;
          cmd.ey = $urandom_range(0, 1) ? 6'd63 : 6'd0;
        end
        default: ;
      endcase
      send_line(cmd);
    end
    calm = 1'b0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
